>>> rtl/c8x_pkg.sv
// ============================================================================
// c8x_pkg: shared types and constants of the CHIP-8 execute unit
// Opcode classes, ALU function codes, status codes and the decoded word that
// travels from the decoder through the queue to the execute stage.
// ============================================================================
package c8x_pkg;

    // Class of a decoded instruction.
    typedef enum logic [3:0] {
        OP_CLS,
        OP_RET,
        OP_JP,
        OP_CALL,
        OP_SE_IMM,
        OP_SNE_IMM,
        OP_SE_REG,
        OP_SNE_REG,
        OP_LD_IMM,
        OP_ADD_IMM,
        OP_ALU,
        OP_LD_I,
        OP_JP_V0,
        OP_RND,
        OP_BAD
    } op_kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNDERFLOW   = 2'd3
    } status_t;

    // ALU function codes of the 8xyn group (low nibble of the opcode).
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Top nibble of the opcode.
    localparam logic [3:0] GRP_SYS    = 4'h0;
    localparam logic [3:0] GRP_JP     = 4'h1;
    localparam logic [3:0] GRP_CALL   = 4'h2;
    localparam logic [3:0] GRP_SE_IMM = 4'h3;
    localparam logic [3:0] GRP_SNE_IM = 4'h4;
    localparam logic [3:0] GRP_SE_REG = 4'h5;
    localparam logic [3:0] GRP_LD_IMM = 4'h6;
    localparam logic [3:0] GRP_ADD_IM = 4'h7;
    localparam logic [3:0] GRP_ALU    = 4'h8;
    localparam logic [3:0] GRP_SNE_RG = 4'h9;
    localparam logic [3:0] GRP_LD_I   = 4'hA;
    localparam logic [3:0] GRP_JP_V0  = 4'hB;
    localparam logic [3:0] GRP_RND    = 4'hC;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0]  FLAG_REG  = 4'hF;
    localparam logic [11:0] RESET_PC  = 12'h200;
    localparam logic [11:0] PC_STEP   = 12'd2;

    // Decoded instruction word held in the queue.
    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  alu;
        logic [7:0]  imm;
        logic [11:0] nnn;
    } dec_word_t;

endpackage

>>> rtl/c8x_front.sv
// ============================================================================
// c8x_front: instruction decoder
// Accepts an opcode word with its random byte and classifies it into a
// decoded word for the execute stage.
// ============================================================================
module c8x_front
    import c8x_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[15:0], random_byte[23:16]
    input  logic        q_full,
    output logic        q_push,
    output dec_word_t   q_word
);

    logic [15:0] opcode;
    logic [7:0]  random_byte;

    assign opcode      = s_tdata[15:0];
    assign random_byte = s_tdata[23:16];
    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;

    always_comb
    begin
        q_word      = '0;
        q_word.kind = OP_BAD;
        q_word.x    = opcode[11:8];
        q_word.y    = opcode[7:4];
        q_word.alu  = opcode[3:0];
        q_word.imm  = opcode[7:0];
        q_word.nnn  = opcode[11:0];
        case (opcode[15:12])
            GRP_SYS:
            begin
                if (opcode == OPC_CLS)
                    q_word.kind = OP_CLS;
                else if (opcode == OPC_RET)
                    q_word.kind = OP_RET;
            end
            GRP_JP:     q_word.kind = OP_JP;
            GRP_CALL:   q_word.kind = OP_CALL;
            GRP_SE_IMM: q_word.kind = OP_SE_IMM;
            GRP_SNE_IM: q_word.kind = OP_SNE_IMM;
            GRP_SE_REG:
            begin
                if (opcode[3:0] == 4'h0)
                    q_word.kind = OP_SE_REG;
            end
            GRP_LD_IMM: q_word.kind = OP_LD_IMM;
            GRP_ADD_IM: q_word.kind = OP_ADD_IMM;
            GRP_ALU:
            begin
                if (opcode[3:0] inside {ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                        ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL})
                    q_word.kind = OP_ALU;
            end
            GRP_SNE_RG:
            begin
                if (opcode[3:0] == 4'h0)
                    q_word.kind = OP_SNE_REG;
            end
            GRP_LD_I:   q_word.kind = OP_LD_I;
            GRP_JP_V0:
            begin
                // The second read port fetches V0 for this jump.
                q_word.kind = OP_JP_V0;
                q_word.y    = 4'h0;
            end
            GRP_RND:
            begin
                q_word.kind = OP_RND;
                q_word.imm  = random_byte & opcode[7:0];
            end
            default:    q_word.kind = OP_BAD;
        endcase
    end

endmodule

>>> rtl/c8x_queue.sv
// ============================================================================
// c8x_queue: two-entry queue of decoded words
// Decouples the decoder from the execute stage.
// ============================================================================
module c8x_queue
    import c8x_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dec_word_t push_word,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output dec_word_t pop_word
);

    dec_word_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

>>> rtl/c8x_back.sv
// ============================================================================
// c8x_back: register read, execute and result register
// Reads Vx and Vy with forwarding, holds the result word for the output, and
// runs one instruction a cycle on architectural state unless m_tready stalls.
// ============================================================================
module c8x_back
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        q_valid,
    input  dec_word_t   q_word,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Architectural state
    logic [7:0]        rf_data_reg [16];
    logic [15:0]       rf_valid_reg;
    logic [15:0]       rf_valid_next;
    logic [11:0]       stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]   sp_reg;
    logic [11:0]       pc_reg;
    logic [11:0]       idx_reg;

    // Read stage
    logic              rd_valid_reg;
    dec_word_t         rd_word_reg;
    logic [7:0]        vx_reg;
    logic [7:0]        vy_reg;

    // Result register
    logic              out_valid_reg;
    logic [39:0]       out_data_reg;
    status_t           out_status_reg;

    // Execute results
    logic              ex_fire;
    logic              rd_take;
    logic [11:0]       ex_pc;
    logic [11:0]       ex_idx;
    logic [SP_W-1:0]   ex_sp;
    logic              ex_rw;
    logic [7:0]        ex_rval;
    logic              ex_fw;
    logic              ex_fval;
    logic              ex_clr;
    status_t           ex_status;
    logic              push_en;
    logic [11:0]       pc_inc;
    logic [11:0]       pc_skip;
    logic [SP_W-1:0]   sp_dec;
    logic [8:0]        sum9;

    assign cfg_ready = 1'b1;
    assign ex_fire   = rd_valid_reg && (!out_valid_reg || m_tready);
    assign rd_take   = q_valid && (!rd_valid_reg || ex_fire);
    assign q_pop     = rd_take;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_status_reg;

    assign pc_inc  = pc_reg + PC_STEP;
    assign pc_skip = pc_inc + PC_STEP;
    assign sp_dec  = sp_reg - SP_W'(1);
    assign sum9    = {1'b0, vx_reg} + {1'b0, vy_reg};

    always_comb
    begin
        ex_pc     = pc_inc;
        ex_idx    = idx_reg;
        ex_sp     = sp_reg;
        ex_rw     = 1'b0;
        ex_rval   = 8'h00;
        ex_fw     = 1'b0;
        ex_fval   = 1'b0;
        ex_clr    = 1'b0;
        ex_status = ST_OK;
        push_en   = 1'b0;
        case (rd_word_reg.kind)
            OP_CLS:     ex_clr = 1'b1;
            OP_RET:
            begin
                if (sp_reg == '0)
                    ex_status = ST_UNDERFLOW;
                else
                begin
                    ex_sp = sp_dec;
                    ex_pc = stack_reg[sp_dec[SIDX_W-1:0]];
                end
            end
            OP_JP:      ex_pc = rd_word_reg.nnn;
            OP_CALL:
            begin
                if (sp_reg == SP_W'(STACK_DEPTH))
                    ex_status = ST_OVERFLOW;
                else
                begin
                    push_en = 1'b1;
                    ex_sp   = sp_reg + SP_W'(1);
                    ex_pc   = rd_word_reg.nnn;
                end
            end
            OP_SE_IMM:  if (vx_reg == rd_word_reg.imm) ex_pc = pc_skip;
            OP_SNE_IMM: if (vx_reg != rd_word_reg.imm) ex_pc = pc_skip;
            OP_SE_REG:  if (vx_reg == vy_reg) ex_pc = pc_skip;
            OP_SNE_REG: if (vx_reg != vy_reg) ex_pc = pc_skip;
            OP_LD_IMM, OP_RND:
            begin
                ex_rw   = 1'b1;
                ex_rval = rd_word_reg.imm;
            end
            OP_ADD_IMM:
            begin
                ex_rw   = 1'b1;
                ex_rval = vx_reg + rd_word_reg.imm;
            end
            OP_ALU:
            begin
                ex_rw = 1'b1;
                case (rd_word_reg.alu)
                    ALU_LD:  ex_rval = vy_reg;
                    ALU_OR:  ex_rval = vx_reg | vy_reg;
                    ALU_AND: ex_rval = vx_reg & vy_reg;
                    ALU_XOR: ex_rval = vx_reg ^ vy_reg;
                    ALU_ADD:
                    begin
                        ex_fw   = 1'b1;
                        ex_fval = sum9[8];
                        ex_rval = sum9[7:0];
                    end
                    ALU_SUB:
                    begin
                        ex_fw   = 1'b1;
                        ex_fval = (vx_reg > vy_reg);
                        ex_rval = vx_reg - vy_reg;
                    end
                    ALU_SHR:
                    begin
                        ex_fw   = 1'b1;
                        ex_fval = vx_reg[0];
                        ex_rval = {1'b0, vx_reg[7:1]};
                    end
                    ALU_SUBN:
                    begin
                        ex_fw   = 1'b1;
                        ex_fval = (vy_reg > vx_reg);
                        ex_rval = vy_reg - vx_reg;
                    end
                    ALU_SHL:
                    begin
                        ex_fw   = 1'b1;
                        ex_fval = vx_reg[7];
                        ex_rval = {vx_reg[6:0], 1'b0};
                    end
                    default: ex_rval = vy_reg;
                endcase
            end
            OP_LD_I:    ex_idx = rd_word_reg.nnn;
            OP_JP_V0:   ex_pc = rd_word_reg.nnn + {4'h0, vy_reg};
            default:    ex_status = ST_UNSUPPORTED;
        endcase
    end

    // Registers that hold a written value after this cycle.
    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (ex_fire && ex_fw)
            rf_valid_next[FLAG_REG] = 1'b1;
        if (ex_fire && ex_rw)
            rf_valid_next[rd_word_reg.x] = 1'b1;
    end

    // Control and architectural state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            sp_reg        <= '0;
            pc_reg        <= RESET_PC;
            idx_reg       <= 12'h000;
        end
        else
        begin
            if (rd_take)
                rd_valid_reg <= 1'b1;
            else if (ex_fire)
                rd_valid_reg <= 1'b0;

            if (ex_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
                pc_reg <= cfg_data;
            else if (ex_fire)
                pc_reg <= ex_pc;

            rf_valid_reg <= rf_valid_next;

            if (ex_fire)
            begin
                sp_reg  <= ex_sp;
                idx_reg <= ex_idx;
            end
        end
    end

    // Register file, return stack, read stage and result payload.
    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            // VF takes the flag unless VF is also Vx, where the byte wins.
            if (ex_fw && !(ex_rw && (rd_word_reg.x == FLAG_REG)))
                rf_data_reg[FLAG_REG] <= {7'h00, ex_fval};
            if (ex_rw)
                rf_data_reg[rd_word_reg.x] <= ex_rval;
            if (push_en)
                stack_reg[sp_reg[SIDX_W-1:0]] <= pc_inc;
            out_data_reg   <= {ex_clr, ex_fval, ex_fw,
                               ex_rw ? ex_rval : 8'h00,
                               ex_rw ? rd_word_reg.x : 4'h0,
                               ex_rw, ex_idx, ex_pc};
            out_status_reg <= ex_status;
        end

        if (rd_take)
        begin
            rd_word_reg <= q_word;
            // Forward the write of the instruction retiring in this cycle.
            if (ex_fire && ex_rw && (rd_word_reg.x == q_word.x))
                vx_reg <= ex_rval;
            else if (ex_fire && ex_fw && (q_word.x == FLAG_REG))
                vx_reg <= {7'h00, ex_fval};
            else if (rf_valid_reg[q_word.x])
                vx_reg <= rf_data_reg[q_word.x];
            else
                vx_reg <= 8'h00;

            if (ex_fire && ex_rw && (rd_word_reg.x == q_word.y))
                vy_reg <= ex_rval;
            else if (ex_fire && ex_fw && (q_word.y == FLAG_REG))
                vy_reg <= {7'h00, ex_fval};
            else if (rf_valid_reg[q_word.y])
                vy_reg <= rf_data_reg[q_word.y];
            else
                vy_reg <= 8'h00;
        end
    end

endmodule

>>> rtl/chip8_instruction_execute_top.sv
// ============================================================================
// chip8_instruction_execute_top: CHIP-8 instruction execute unit
// Executes one fetched opcode per word: control flow, skips, loads, ALU ops
// with the VF flag, I load and random AND, and reports the resulting state.
// ============================================================================
//
//  Channel   | Direction | Signals                         | Contents
//  ----------+-----------+---------------------------------+---------------------------
//  s_*       | in        | s_tvalid, s_tready, s_tdata     | opcode, random byte
//  m_*       | out       | m_tvalid, m_tready, m_tdata,    | next PC, I, Vx write,
//            |           | m_tuser                         | VF write, clear, status
//  cfg_*     | in        | cfg_valid, cfg_ready, cfg_data  | start address (loads PC)
//
//  Throughput is one word per cycle while m_tready does not stall the
//  result; the execute stage then retires one instruction per clock, with
//  register reads forwarded from the previous one. An accepted word passes
//  through the queue, then the register read stage, and the execute stage
//  then loads the result register that drives m_tvalid.
//  Reset clears the registers V0..VF to zero (valid bits), the stack pointer
//  and I, and loads PC with 0x200. A configuration write loads PC at once.
//  A stalled m_tready holds the result, then the read stage, then fills the
//  two-entry queue before s_tready drops.
//
module chip8_instruction_execute_top
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: start address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    // Instruction words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[15:0], random_byte[23:16]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // next_pc[11:0], index_value[23:12], reg_write[24],
                                   // reg_num[28:25], reg_value[36:29], flag_write[37],
                                   // flag_value[38], clear_screen[39]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic      q_full;
    logic      q_push;
    dec_word_t q_in_word;
    logic      q_pop;
    logic      q_valid;
    dec_word_t q_out_word;

    // Front: decode and classify the incoming opcode.
    c8x_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (q_in_word)
    );

    // Short queue so that the decoder and the execute stage stall separately.
    c8x_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in_word),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_word  (q_out_word)
    );

    // Back: register read, execute, architectural state and result register.
    c8x_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_word    (q_out_word),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // A clear-screen result carries no register write and an ok status.
    a_clear_is_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[39]) |-> (!m_tdata[24] && (m_tuser == ST_OK)))
        else $error("clear screen combined with a register write or bad status");

    // VF is only written by ALU ops, which always write Vx as well.
    a_flag_needs_reg: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[37]) |-> m_tdata[24])
        else $error("flag write without register write");

    // Without a register write the register fields read zero.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[24]) |-> ((m_tdata[28:25] == 4'h0) && (m_tdata[36:29] == 8'h00)))
        else $error("register fields nonzero without register write");

    // A failing instruction changes no general register.
    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (!m_tdata[24] && !m_tdata[37]))
        else $error("register written by a failing instruction");
`endif

endmodule
